FILE: sv/arsl_pkg.sv
`timescale 1ns / 1ps

package arsl_pkg;

    localparam int CNT_W  = 9;
    localparam int ADDR_W = 16;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic              func;
        logic [7:0]        entry_slot;
        logic [ADDR_W-1:0] entry_start;
        logic [ADDR_W-1:0] entry_end;
        logic              entry_is_label;
        logic [ADDR_W-1:0] lookup_address;
        logic [CNT_W-1:0]  start_index;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [7:0]       match_index;
        logic [CNT_W-1:0] next_hint;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic              is_label;
    } entry_t;

endpackage

FILE: sv/arsl_table.sv
`timescale 1ns / 1ps

module arsl_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  arsl_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output arsl_pkg::entry_t rd_data
);
    import arsl_pkg::*;

    entry_t tbl_mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/arsl_scan.sv
`timescale 1ns / 1ps

module arsl_scan #(
    parameter int TABLE_DEPTH = 256,
    parameter int AW          = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  arsl_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output arsl_pkg::rsp_t                rsp,
    input  logic [arsl_pkg::CNT_W-1:0]    limit,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output arsl_pkg::entry_t              wr_data,
    output logic [AW-1:0]                 rd_addr,
    input  arsl_pkg::entry_t              rd_data
);
    import arsl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  from_reg, from_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              pass_reg, pass_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    logic              accept;
    logic              skip;
    logic              hit;
    logic              beyond;
    logic [CNT_W-1:0]  nxt;
    logic              last;
    logic              out_load;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_load  = (state_reg == S_OUT) && (!rsp_valid_reg || !rsp_stall);

    assign skip   = !pass_reg && rd_data.is_label;
    assign hit    = !skip && (rd_data.start_addr <= addr_reg) && (addr_reg <= rd_data.end_addr);
    assign beyond = !skip && (rd_data.start_addr > addr_reg);
    assign nxt    = idx_reg + CNT_W'(1);
    assign last   = (nxt >= limit);

    assign wr_en   = accept && (req.func == FUNC_WRITE) && (32'(req.entry_slot) < TABLE_DEPTH);
    assign wr_addr = AW'(req.entry_slot);
    assign wr_data = '{start_addr: req.entry_start,
                       end_addr:   req.entry_end,
                       is_label:   req.entry_is_label};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        from_next  = from_reg;
        addr_next  = addr_reg;
        pass_next  = pass_reg;
        res_next   = res_reg;
        rd_addr    = AW'(idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = AW'(req.start_index);
                if (accept && (req.func == FUNC_LOOKUP))
                begin
                    from_next = req.start_index;
                    idx_next  = req.start_index;
                    addr_next = req.lookup_address;
                    pass_next = 1'b0;
                    if (req.start_index >= limit)
                    begin
                        res_next   = '{found: 1'b0, match_index: 8'd0,
                                       next_hint: req.start_index};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    res_next   = '{found: 1'b1, match_index: 8'(idx_reg),
                                   next_hint: idx_reg};
                    state_next = S_OUT;
                end
                else if (beyond || last)
                begin
                    if (!pass_reg)
                    begin
                        // retry with labels included
                        pass_next = 1'b1;
                        idx_next  = from_reg;
                        rd_addr   = AW'(from_reg);
                    end
                    else
                    begin
                        res_next   = '{found: 1'b0, match_index: 8'd0,
                                       next_hint: beyond ? idx_reg : nxt};
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    idx_next = nxt;
                    rd_addr  = AW'(nxt);
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        from_reg <= from_next;
        addr_reg <= addr_next;
        pass_reg <= pass_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/address_range_symbol_lookup_core.sv
// Address range symbol lookup.
// req channel (req_valid/req_stall/req): one word per item. func write stores
//   entry_slot <- {entry_start, entry_end, entry_is_label}; func lookup scans
//   the table from start_index for the range holding lookup_address.
// rsp channel (rsp_valid/rsp_stall/rsp): one word per lookup, none per write.
// cfg channel (cfg_valid/cfg_ready/cfg_data): sets symbol_count; always ready;
//   the user must write it only while the core is idle; the core does not enforce this.
// Write: stored when accepted, next word accepted the following cycle.
// Lookup: one table entry per cycle through the single synchronous read port,
//   first pass skipping labels, second pass only on a miss. One lookup in
//   flight at a time: the next word is accepted only once the result has
//   moved into the rsp register.
// The rsp register decouples the sides: a finished word may sit stalled
// while the core takes new writes or starts a new lookup; that lookup then
// waits at its end until rsp frees up.
// Reset clears symbol_count and the control state; table contents are
// undefined until written, no clearing pass.
`timescale 1ns / 1ps

module address_range_symbol_lookup_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  arsl_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output arsl_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [arsl_pkg::CNT_W-1:0] cfg_data
);
    import arsl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] limit;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_data;
    logic [AW-1:0]    rd_addr;
    entry_t           rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    assign limit = (32'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_reg;

    arsl_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    arsl_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .limit     (limit),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

endmodule

FILE: sv/arsl_checker.sv
`timescale 1ns / 1ps

module arsl_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input arsl_pkg::req_t             req,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input arsl_pkg::rsp_t             rsp
);
    import arsl_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("rsp word changed while stalled");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.match_index == 8'd0)
        else $error("miss with nonzero match_index");

    a_hit_hint: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.match_index == rsp.next_hint[7:0])
        else $error("hit with hint not at match");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.func == FUNC_WRITE) |=> !$rose(rsp_valid))
        else $error("write word produced a response");

endmodule

bind address_range_symbol_lookup_core arsl_checker u_arsl_checker (.*);
